/* rtl/c2p_pkg.sv */
// c2p_pkg: shared types and constants for the chunky-to-planar dither block.
// No dependencies; used by every module in rtl/.
package c2p_pkg;

    localparam int COLOR_W     = 4;
    localparam int PLANES      = 4;
    localparam int WORD_W      = 16;
    localparam int POS_W       = $clog2(WORD_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WORD_W - 1);

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       phase;
        logic       end_of_line;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] plane0_word;
        logic [WORD_W-1:0] plane1_word;
        logic [WORD_W-1:0] plane2_word;
        logic [WORD_W-1:0] plane3_word;
    } t_out;

    // Classified request: colour to use at an even / odd pixel position.
    typedef struct packed {
        logic [COLOR_W-1:0] col_even;
        logic [COLOR_W-1:0] col_odd;
        logic               dbl;
        logic               eol;
    } t_cmd;

endpackage

/* rtl/c2p_front.sv */
// c2p_front: accepts pixel requests, holds the mode register and computes
// the colours for both position parities. Depends on c2p_pkg.
module c2p_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_data,
    input  logic         push,
    input  c2p_pkg::t_in i_in,
    input  logic         i_q_full,
    output logic         o_q_push,
    output c2p_pkg::t_cmd o_cmd
);

    logic                        r_pixel_mode;
    logic [c2p_pkg::COLOR_W-1:0] base;
    logic [c2p_pkg::COLOR_W-1:0] with_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_pixel_mode <= i_cfg_data;
        end
    end

    always_comb begin
        base           = i_in.pixel_byte[3:0];
        with_off       = base + i_in.pixel_byte[7:4];
        o_cmd.col_even = i_in.phase ? with_off : base;
        o_cmd.col_odd  = i_in.phase ? base : with_off;
        o_cmd.dbl      = r_pixel_mode;
        o_cmd.eol      = i_in.end_of_line;
        o_q_push       = push && !i_q_full;
    end

endmodule

/* rtl/c2p_cmd_fifo.sv */
// c2p_cmd_fifo: short queue of classified requests between front and back.
// Depends on c2p_pkg.
module c2p_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  c2p_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output c2p_pkg::t_cmd o_data
);

    c2p_pkg::t_cmd             r_mem [c2p_pkg::QUEUE_DEPTH];
    logic [c2p_pkg::PTR_W-1:0] r_wptr;
    logic [c2p_pkg::PTR_W-1:0] r_rptr;
    logic [c2p_pkg::CNT_W-1:0] r_count;
    logic                      do_push;
    logic                      do_pop;

    assign o_full  = r_count == c2p_pkg::CNT_W'(c2p_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + c2p_pkg::PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + c2p_pkg::PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + c2p_pkg::CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - c2p_pkg::CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/c2p_back.sv */
// c2p_back: shifts pixel colours into the four plane words and queues the
// finished groups for the result side. Depends on c2p_pkg.
module c2p_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_empty,
    input  c2p_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          empty,
    input  logic          pop,
    output c2p_pkg::t_out o_out
);

    logic [c2p_pkg::WORD_W-1:0] r_shift [c2p_pkg::PLANES];
    logic [c2p_pkg::POS_W-1:0]  r_pos;
    logic [c2p_pkg::WORD_W-1:0] n_shift [c2p_pkg::PLANES];
    logic [c2p_pkg::POS_W-1:0]  n_pos;

    c2p_pkg::t_out             r_oq_mem [c2p_pkg::QUEUE_DEPTH];
    logic [c2p_pkg::PTR_W-1:0] r_oq_wptr;
    logic [c2p_pkg::PTR_W-1:0] r_oq_rptr;
    logic [c2p_pkg::CNT_W-1:0] r_oq_count;

    logic [c2p_pkg::COLOR_W-1:0] c1;
    logic [c2p_pkg::COLOR_W-1:0] c2;
    logic [c2p_pkg::WORD_W-1:0]  s1 [c2p_pkg::PLANES];
    logic [c2p_pkg::WORD_W-1:0]  s2 [c2p_pkg::PLANES];
    logic [c2p_pkg::WORD_W-1:0]  words [c2p_pkg::PLANES];
    logic                        done1;
    logic                        done2;
    logic                        oq_full;
    logic                        take;
    logic                        oq_push;
    logic                        oq_pop;
    c2p_pkg::t_out               res;

    assign oq_full   = r_oq_count == c2p_pkg::CNT_W'(c2p_pkg::QUEUE_DEPTH);
    assign empty     = r_oq_count == '0;
    assign o_out     = r_oq_mem[r_oq_rptr];
    assign take      = !i_cmd_empty && !oq_full;
    assign o_cmd_pop = take;
    assign oq_pop    = pop && !empty;

    always_comb begin
        c1    = r_pos[0] ? i_cmd.col_odd : i_cmd.col_even;
        c2    = r_pos[0] ? i_cmd.col_even : i_cmd.col_odd;
        done1 = r_pos == c2p_pkg::POS_LAST;
        done2 = i_cmd.dbl && (r_pos == c2p_pkg::POS_LAST - c2p_pkg::POS_W'(1));
        for (int b = 0; b < c2p_pkg::PLANES; b++) begin
            s1[b]    = {r_shift[b][c2p_pkg::WORD_W-2:0], c1[b]};
            s2[b]    = {s1[b][c2p_pkg::WORD_W-2:0], c2[b]};
            words[b] = done1 ? s1[b] : s2[b];
            if (i_cmd.eol) begin
                n_shift[b] = '0;
            end else if (i_cmd.dbl) begin
                n_shift[b] = s2[b];
            end else begin
                n_shift[b] = s1[b];
            end
        end
        n_pos = i_cmd.eol ? '0
              : r_pos + c2p_pkg::POS_W'(1) + c2p_pkg::POS_W'(i_cmd.dbl);
        res.plane0_word = words[0];
        res.plane1_word = words[1];
        res.plane2_word = words[2];
        res.plane3_word = words[3];
        oq_push = take && (done1 || done2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            for (int b = 0; b < c2p_pkg::PLANES; b++) begin
                r_shift[b] <= '0;
            end
        end else if (take) begin
            r_pos <= n_pos;
            for (int b = 0; b < c2p_pkg::PLANES; b++) begin
                r_shift[b] <= n_shift[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq_mem[r_oq_wptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wptr  <= '0;
            r_oq_rptr  <= '0;
            r_oq_count <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wptr <= r_oq_wptr + c2p_pkg::PTR_W'(1);
            end
            if (oq_pop) begin
                r_oq_rptr <= r_oq_rptr + c2p_pkg::PTR_W'(1);
            end
            if (oq_push && !oq_pop) begin
                r_oq_count <= r_oq_count + c2p_pkg::CNT_W'(1);
            end else if (oq_pop && !oq_push) begin
                r_oq_count <= r_oq_count - c2p_pkg::CNT_W'(1);
            end
        end
    end

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_count <= c2p_pkg::CNT_W'(c2p_pkg::QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_cmd.eol |=> r_pos == '0)
        else $error("position not cleared after end of line");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !i_cmd.eol |=> r_pos == $past(r_pos) + c2p_pkg::POS_W'(1)
            + c2p_pkg::POS_W'($past(i_cmd.dbl)))
        else $error("position advanced wrongly");

    a_emit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_push |-> r_pos == c2p_pkg::POS_LAST
            || (i_cmd.dbl && r_pos == c2p_pkg::POS_LAST - c2p_pkg::POS_W'(1)))
        else $error("group emitted off the group boundary");

endmodule

/* rtl/chunky_to_planar_dither.sv */
// chunky_to_planar_dither: top level, front classifier, request queue and
// plane shifter. Depends on c2p_pkg, c2p_front, c2p_cmd_fifo, c2p_back.
//
// Input side: drive i_in with push high; a request is taken on a rising edge
// with push high and full low. Each byte yields one pixel, or two when the
// mode register (i_cfg_we / i_cfg_data) is 1. Write the mode only while idle.
// Result side: while empty is low, o_out holds the oldest group of four
// 16-bit plane words; it is taken on an edge with pop high.
// Throughput: one byte per cycle, sustained, as long as results are drained.
// A byte that completes a group sits in the request queue until the shifter
// takes it and writes the group into the result queue; the shifter waits
// while the result queue is full.
// End of line drops any partial group and restarts at pixel position zero.
// Reset (synchronous, active low) clears the mode, position, plane words and
// both queues. If pop stays low, the result queue fills, the shifter stalls,
// and full rises once the two-entry request queue is full.
module chunky_to_planar_dither (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    input  logic          push,
    output logic          full,
    input  c2p_pkg::t_in  i_in,
    output logic          empty,
    input  logic          pop,
    output c2p_pkg::t_out o_out
);

    c2p_pkg::t_cmd cmd_in;
    c2p_pkg::t_cmd cmd_out;
    logic          q_push;
    logic          q_empty;
    logic          q_pop;

    c2p_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .i_in       (i_in),
        .i_q_full   (full),
        .o_q_push   (q_push),
        .o_cmd      (cmd_in)
    );

    c2p_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (cmd_out)
    );

    c2p_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );

endmodule

/* bench/chunky_to_planar_dither_tb.sv */
// chunky_to_planar_dither_tb: self-checking bench for the chunky-to-planar dither block.
// A short table of directed requests is followed by random lines under random flow control.
// Depends on c2p_pkg and the chunky_to_planar_dither RTL.
module chunky_to_planar_dither_tb;

    typedef enum logic {ROW_PIXELS, ROW_MODE} t_row_kind;

    typedef struct {
        t_row_kind     kind;
        logic          mode;
        c2p_pkg::t_in  req;
        int            reps;
        bit            typed;
        c2p_pkg::t_out group;
    } t_stim_row;

    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int MODE_PHASES   = 12;
    localparam int REPORT_MAX    = 10;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic          i_cfg_data;
    logic          push;
    logic          full;
    logic          empty;
    logic          pop;
    c2p_pkg::t_in  i_in;
    c2p_pkg::t_out o_out;

    logic [c2p_pkg::WORD_W-1:0] plane_acc [c2p_pkg::PLANES];
    logic [c2p_pkg::POS_W-1:0]  pix_pos;
    logic                       dbl_mode;

    c2p_pkg::t_out pending_groups[$];
    t_stim_row     rows[$];

    int            mismatches  = 0;
    int            groups_seen = 0;
    int            items_sent  = 0;
    int            mode_writes = 0;
    int            idle_cycles = 0;
    int            burst_left  = 0;
    bit            typed_now   = 0;
    c2p_pkg::t_out typed_group = '0;

    chunky_to_planar_dither dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Color of the next pixel at the current position.
    function automatic logic [c2p_pkg::COLOR_W-1:0] pixel_color(c2p_pkg::t_in req);
        logic [c2p_pkg::COLOR_W-1:0] base;
        logic [c2p_pkg::COLOR_W-1:0] mixed;
        base  = req.pixel_byte[3:0];
        mixed = base + req.pixel_byte[7:4];
        return (req.phase ^ pix_pos[0]) ? mixed : base;
    endfunction

    function automatic void shift_pixel(input logic [c2p_pkg::COLOR_W-1:0] color,
                                        inout bit done, inout c2p_pkg::t_out grp);
        for (int b = 0; b < c2p_pkg::PLANES; b++) begin
            plane_acc[b] = {plane_acc[b][c2p_pkg::WORD_W-2:0], color[b]};
        end
        if (pix_pos == c2p_pkg::POS_LAST) begin
            grp.plane0_word = plane_acc[0];
            grp.plane1_word = plane_acc[1];
            grp.plane2_word = plane_acc[2];
            grp.plane3_word = plane_acc[3];
            done = 1'b1;
        end
        pix_pos = pix_pos + 1'b1;
    endfunction

    function automatic void predict_group(c2p_pkg::t_in req);
        bit            done;
        c2p_pkg::t_out grp;
        done = 1'b0;
        grp  = '0;
        shift_pixel(pixel_color(req), done, grp);
        if (dbl_mode) begin
            shift_pixel(pixel_color(req), done, grp);
        end
        if (req.end_of_line) begin
            for (int b = 0; b < c2p_pkg::PLANES; b++) begin
                plane_acc[b] = '0;
            end
            pix_pos = '0;
        end
        if (done) begin
            pending_groups.push_back(typed_now ? typed_group : grp);
        end
    endfunction

    function automatic void note(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic void check_group(c2p_pkg::t_out got);
        c2p_pkg::t_out              want;
        logic [c2p_pkg::WORD_W-1:0] w_exp;
        logic [c2p_pkg::WORD_W-1:0] w_act;
        groups_seen++;
        if (pending_groups.size() == 0) begin
            note($sformatf("unexpected plane group %h", got));
            return;
        end
        want = pending_groups.pop_front();
        for (int k = 0; k < c2p_pkg::PLANES; k++) begin
            w_exp = want[(c2p_pkg::PLANES-1-k)*c2p_pkg::WORD_W +: c2p_pkg::WORD_W];
            w_act = got[(c2p_pkg::PLANES-1-k)*c2p_pkg::WORD_W +: c2p_pkg::WORD_W];
            if (w_act !== w_exp) begin
                note($sformatf("group %0d plane%0d exp %h got %h", groups_seen, k, w_exp, w_act));
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                predict_group(i_in);
                items_sent++;
            end
            if (pop && !empty) begin
                check_group(o_out);
            end
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    // Receiver: stall style is chosen at random from four and changed periodically.
    initial begin
        int style;
        int window;
        int run_left;
        style    = 0;
        window   = 0;
        run_left = 0;
        pop      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (window == 0) begin
                style  = $urandom_range(0, 3);
                window = 48;
            end
            window--;
            case (style)
                0: pop = 1'b1;
                1: pop = 1'($urandom_range(0, 1));
                2: pop = ($urandom_range(0, 3) == 0);
                default: begin
                    if (run_left == 0) begin
                        run_left = $urandom_range(1, 12);
                        pop      = ~pop;
                    end
                    run_left--;
                end
            endcase
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    task automatic send_item(c2p_pkg::t_in req);
        push = 1'b1;
        i_in = req;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic paced_send(c2p_pkg::t_in req);
        int gap;
        if (burst_left == 0) begin
            gap  = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_item(req);
    endtask

    task automatic settle();
        push = 1'b0;
        while (pending_groups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_mode(logic value);
        settle();
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        dbl_mode   = value;
        mode_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic void add_row(t_row_kind kind, logic mode, logic [7:0] pix_byte,
                                    logic ph, logic eol, int reps, bit typed,
                                    c2p_pkg::t_out group);
        t_stim_row r;
        r.kind  = kind;
        r.mode  = mode;
        r.req   = '{pixel_byte: pix_byte, phase: ph, end_of_line: eol};
        r.reps  = reps;
        r.typed = typed;
        r.group = group;
        rows.push_back(r);
    endfunction

    task automatic send_line();
        int           kind;
        int           len;
        bit           ph;
        c2p_pkg::t_in req;
        kind = $urandom_range(0, 9);
        ph   = 1'($urandom_range(0, 1));
        if (kind <= 6) begin
            len = $urandom_range(1, 3) * (dbl_mode ? 8 : 16);
            if ($urandom_range(0, 3) == 0) begin
                len += $urandom_range(1, 3);
            end
        end else if (kind == 7) begin
            len = $urandom_range(1, 7);
        end else begin
            len = $urandom_range(10, 40);
        end
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
                0: req.pixel_byte = 8'h00;
                1: req.pixel_byte = 8'hFF;
                default: req.pixel_byte = 8'($urandom_range(0, 255));
            endcase
            // noise lines flip phase and end at random; long lines carry on unterminated
            req.phase       = (kind == 8) ? 1'($urandom_range(0, 1)) : ph;
            req.end_of_line = (kind == 8) ? ($urandom_range(0, 9) == 0) :
                              (kind != 9 && i == len - 1);
            paced_send(req);
        end
    endtask

    initial begin
        t_stim_row row;
        int        phase_goal;
        logic      mode_v;

        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = 1'b0;
        push       = 1'b0;
        i_in       = '0;
        for (int b = 0; b < c2p_pkg::PLANES; b++) begin
            plane_acc[b] = '0;
        end
        pix_pos  = '0;
        dbl_mode = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_row(ROW_MODE,   1'b1, 8'h00, 1'b0, 1'b0, 0, 0, '0);
        add_row(ROW_PIXELS, 1'b0, 8'hFF, 1'b0, 1'b0, 8, 1,
                '{16'hAAAA, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        add_row(ROW_PIXELS, 1'b0, 8'h5A, 1'b1, 1'b1, 1, 0, '0);
        add_row(ROW_MODE,   1'b0, 8'h00, 1'b0, 1'b0, 0, 0, '0);
        add_row(ROW_PIXELS, 1'b0, 8'h00, 1'b0, 1'b0, 1, 0, '0);
        add_row(ROW_MODE,   1'b1, 8'h00, 1'b0, 1'b0, 0, 0, '0);
        add_row(ROW_PIXELS, 1'b0, 8'hF0, 1'b1, 1'b0, 7, 0, '0);
        add_row(ROW_PIXELS, 1'b0, 8'h81, 1'b0, 1'b1, 1, 0, '0);

        foreach (rows[i]) begin
            row = rows[i];
            if (row.kind == ROW_MODE) begin
                write_mode(row.mode);
            end else begin
                for (int r = 0; r < row.reps; r++) begin
                    typed_now   = row.typed && (r == row.reps - 1);
                    typed_group = row.group;
                    send_item(row.req);
                end
                typed_now = 1'b0;
            end
        end

        for (int m = 0; m < MODE_PHASES; m++) begin
            case (m % 4)
                0: mode_v = 1'b0;
                1: mode_v = 1'b1;
                default: mode_v = 1'($urandom_range(0, 1));
            endcase
            write_mode(mode_v);
            phase_goal = items_sent + RANDOM_ITEMS / MODE_PHASES;
            while (items_sent < phase_goal) send_line();
        end

        push = 1'b0;
        while (pending_groups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d pixel requests over %0d mode settings, %0d plane groups checked",
                 items_sent, mode_writes, groups_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
